// ===== rtl/tdpt_pkg.sv =====
package tdpt_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_DONE
    } tdpt_state_t;

    // first trial divisor and the stride between trials (odd divisors only)
    localparam int FIRST_DIVISOR = 3;
    localparam int DIVISOR_STEP  = 2;

endpackage

// ===== rtl/trial_division_prime_test_top.sv =====
// 0, 1, 2, 3 and even values go from IDLE straight to DONE, which loads the output register
// once it is free; other values pass through DIV and CHECK once per odd trial divisor 3, 5, 7, ...
// up to about sqrt(n), stopping at the first divisor that divides n
// throughput: one item at a time, set by the one-bit-per-cycle restoring divider
// s_ready is high only while idle; a finished result may wait in the output register
// reset: aresetn synchronous active low, clears the sequencer and m_valid
module trial_division_prime_test_top #(
    parameter int VALUE_WIDTH = 31
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [VALUE_WIDTH-1:0] s_candidate,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_is_prime
);

    localparam int W     = VALUE_WIDTH;
    localparam int CNT_W = $clog2(VALUE_WIDTH);

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(VALUE_WIDTH - 1);
    localparam logic [W-1:0]     DIV_FIRST = W'(tdpt_pkg::FIRST_DIVISOR);
    localparam logic [W-1:0]     DIV_STEP  = W'(tdpt_pkg::DIVISOR_STEP);

    // sequencer state
    tdpt_pkg::tdpt_state_t state_reg, state_next;

    // operand and trial divisor
    logic [W-1:0]     value_reg,   value_next;
    logic [W-1:0]     divisor_reg, divisor_next;

    // shared restoring divider: quotient shifts in while dividend bits shift out
    logic [W-1:0]     quo_reg,     quo_next;
    logic [W-1:0]     rem_reg,     rem_next;
    logic [CNT_W-1:0] step_reg,    step_next;

    // answer waiting for the output register, and the output register itself
    logic             result_reg,  result_next;
    logic             m_valid_reg, m_valid_next;
    logic             m_prime_reg, m_prime_next;

    logic             in_fire;
    logic             out_free;
    logic             early_exit;
    logic             early_result;
    logic [W:0]       trial;
    logic [W:0]       diff;
    logic             past_bound;
    logic             rem_zero;

    assign s_ready    = (state_reg == tdpt_pkg::ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_is_prime = m_prime_reg;

    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // values below 4 and even values are settled without any division
    always_comb begin
        priority if (s_candidate[W-1:1] == '0) begin
            early_exit   = 1'b1;      // zero and one are not prime
            early_result = 1'b0;
        end else if (s_candidate[W-1:2] == '0) begin
            early_exit   = 1'b1;      // two and three are prime
            early_result = 1'b1;
        end else if (!s_candidate[0]) begin
            early_exit   = 1'b1;      // even and at least four
            early_result = 1'b0;
        end else begin
            early_exit   = 1'b0;
            early_result = 1'b0;
        end
    end

    // one divider step: shift in next dividend bit, subtract if it fits
    assign trial = {rem_reg, quo_reg[W-1]};
    assign diff  = trial - {1'b0, divisor_reg};

    // after the divide: quotient below divisor means divisor squared exceeds value
    assign past_bound = (divisor_reg > quo_reg);
    assign rem_zero   = (rem_reg == '0);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tdpt_pkg::ST_IDLE: begin
                if (in_fire) begin
                    state_next = early_exit ? tdpt_pkg::ST_DONE : tdpt_pkg::ST_DIV;
                end
            end
            tdpt_pkg::ST_DIV: begin
                if (step_reg == LAST_STEP) begin
                    state_next = tdpt_pkg::ST_CHECK;
                end
            end
            tdpt_pkg::ST_CHECK: begin
                if (past_bound || rem_zero) begin
                    state_next = tdpt_pkg::ST_DONE;
                end else begin
                    state_next = tdpt_pkg::ST_DIV;
                end
            end
            tdpt_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = tdpt_pkg::ST_IDLE;
                end
            end
            default: state_next = tdpt_pkg::ST_IDLE;
        endcase
    end

    // datapath and output register
    always_comb begin
        value_next   = value_reg;
        divisor_next = divisor_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        step_next    = step_reg;
        result_next  = result_reg;
        m_prime_next = m_prime_reg;
        m_valid_next = m_valid_reg && !m_ready;

        unique case (state_reg)
            tdpt_pkg::ST_IDLE: begin
                if (in_fire) begin
                    value_next   = s_candidate;
                    divisor_next = DIV_FIRST;
                    quo_next     = s_candidate;
                    rem_next     = '0;
                    step_next    = '0;
                    result_next  = early_result;
                end
            end
            tdpt_pkg::ST_DIV: begin
                if (!diff[W]) begin
                    rem_next = diff[W-1:0];
                end else begin
                    rem_next = trial[W-1:0];
                end
                quo_next  = {quo_reg[W-2:0], !diff[W]};
                step_next = step_reg + 1'b1;
            end
            tdpt_pkg::ST_CHECK: begin
                priority if (past_bound) begin
                    result_next = 1'b1;
                end else if (rem_zero) begin
                    result_next = 1'b0;
                end else begin
                    // next odd divisor, restart the divider on the same value
                    divisor_next = divisor_reg + DIV_STEP;
                    quo_next     = value_reg;
                    rem_next     = '0;
                    step_next    = '0;
                end
            end
            tdpt_pkg::ST_DONE: begin
                if (out_free) begin
                    m_prime_next = result_reg;
                    m_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tdpt_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge aclk) begin
        value_reg   <= value_next;
        divisor_reg <= divisor_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        step_reg    <= step_next;
        result_reg  <= result_next;
        m_prime_reg <= m_prime_next;
    end

    // trial divisors are always odd
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == tdpt_pkg::ST_DIV |-> divisor_reg[0])
        else $error("even trial divisor");

    // a divide is only started with a divisor below the value
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == tdpt_pkg::ST_DIV |-> divisor_reg < value_reg)
        else $error("trial divisor not below value");

    // the divider runs exactly VALUE_WIDTH steps before the check
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == tdpt_pkg::ST_DIV && step_reg == LAST_STEP
        |=> state_reg == tdpt_pkg::ST_CHECK)
        else $error("divider step count mismatch");

    // a result only appears when the sequencer hands one over
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg ##1 m_valid_reg |-> $past(state_reg == tdpt_pkg::ST_DONE))
        else $error("result without finished test");

endmodule

// ===== verif/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_WIDTH = 31;
    localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_WIDTH) - 1;

    // random part size, on top of the directed list
    localparam int RANDOM_ITEMS   = 85;
    // long receiver hold-off, started once enough transactions went in
    localparam int HOLD_AFTER     = 40;
    localparam int HOLD_CYCLES    = 400;
    // drain past the last result, the block answers in one result per item
    localparam int DRAIN_CYCLES   = 64;
    // slowest item is 2^31-1, a prime: about 23170 odd divisors, each a full divide and check,
    // all with no transaction at all, and the limit leaves ample margin over that run
    localparam int WATCHDOG_LIMIT = 3_000_000;

    // extremes, tiny special values, prime squares at the square bound, large primes
    localparam bit [VALUE_WIDTH-1:0] DIRECTED_VALUES [18] = '{
        31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd9, 31'd15, 31'd25, 31'd49,
        31'd97, 31'd121, 31'd65521, 31'd1000003, 31'd1073741824, 31'd1431655765,
        31'd2147483646, 31'd2147483647
    };

    typedef struct {
        logic [VALUE_WIDTH-1:0] candidate;
        logic                   is_prime;
    } verdict_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [VALUE_WIDTH-1:0] s_candidate = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_is_prime;

    logic [VALUE_WIDTH-1:0] pending_candidates [$];
    verdict_t               expected_verdicts [$];

    int   total_items    = 0;
    int   items_accepted = 0;
    int   results_seen   = 0;
    int   error_count    = 0;
    int   stall_cycles   = 0;
    int   hold_left      = 0;
    bit   hold_done      = 1'b0;
    logic s_taken        = 1'b0;
    int   idle_phase;

    trial_division_prime_test_top #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_candidate(s_candidate),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_is_prime (m_is_prime)
    );

    // 4 ns clock
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // three idling phases by progress: receiver-heavy gaps, sender-heavy, then none
    assign idle_phase = (total_items == 0) ? 0 : items_accepted * 3 / total_items;

    // trial division over odd divisors, bounded by d <= n / d so no square is formed
    function automatic logic is_prime_by_trial_division(input logic [VALUE_WIDTH-1:0] value);
        longint unsigned n;
        longint unsigned d;
        n = 64'(value);
        if (n < 2)
            return 1'b0;
        if (n < 4)
            return 1'b1;
        if (n[0] == 1'b0)
            return 1'b0;
        for (d = 3; d <= n / d; d += 2) begin
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // one line per mismatch, counted for the final verdict
    task automatic report_mismatch(input string what, input logic [VALUE_WIDTH-1:0] cand,
                                   input logic want, input logic got);
        $display("mismatch: %s, candidate %0d, expected is_prime %b, got %b",
                 what, cand, want, got);
        error_count++;
    endtask

    // input driver: a new transaction goes out at the falling edge once the previous
    // one was taken, valid stays up with a stable payload until accepted
    always @(negedge aclk) begin : input_driver
        int idle_pct;
        idle_pct = (idle_phase == 0) ? 38 : (idle_phase == 1) ? 49 : 0;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (pending_candidates.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                s_valid     <= 1'b1;
                s_candidate <= pending_candidates.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver: random ready, plus one long hold-off so the output register
    // fills and the block stops taking input while the sender keeps offering
    always @(negedge aclk) begin : result_receiver
        int idle_pct;
        idle_pct = (idle_phase == 0) ? 49 : (idle_phase == 1) ? 38 : 0;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!hold_done && items_accepted >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    // monitor: sample both channels at the rising edge, predict on input transactions,
    // check result transactions in order, and watch for a hang
    always @(posedge aclk) begin : monitor
        verdict_t oldest;
        verdict_t predicted;
        logic     progress;
        progress = 1'b0;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predicted.candidate = s_candidate;
                predicted.is_prime  = is_prime_by_trial_division(s_candidate);
                expected_verdicts.push_back(predicted);
                items_accepted <= items_accepted + 1;
                progress = 1'b1;
            end
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                progress = 1'b1;
                if (expected_verdicts.size() == 0) begin
                    report_mismatch("result with nothing outstanding", 'x, 1'bx, m_is_prime);
                end else begin
                    oldest = expected_verdicts.pop_front();
                    if (m_is_prime !== oldest.is_prime)
                        report_mismatch("is_prime", oldest.candidate, oldest.is_prime,
                                        m_is_prime);
                end
            end
        end
        s_taken <= aresetn && s_valid && s_ready;

        // watchdog: cycles in a row without any transaction
        if (progress || !aresetn) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", stall_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // stimulus and end of run
    initial begin : stimulus
        logic [VALUE_WIDTH-1:0] value;
        longint unsigned        factor;
        longint unsigned        multiplier;
        longint unsigned        root;
        int                     pick;

        // directed part first
        foreach (DIRECTED_VALUES[i])
            pending_candidates.push_back(DIRECTED_VALUES[i]);

        // random part: mostly cheap values so the large primes above dominate the run
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            pick = int'($urandom_range(0, 99));
            if (pick < 35) begin
                // small values, primes and composites alike
                value = VALUE_WIDTH'($urandom_range(0, 4095));
            end else if (pick < 55) begin
                // large composite with a small odd factor, full width reached
                factor     = 64'(2 * $urandom_range(1, 49) + 1);
                multiplier = 64'($urandom_range(1, int'(VALUE_MAX / factor)));
                value      = VALUE_WIDTH'(factor * multiplier);
            end else if (pick < 70) begin
                // any even value over the full width
                value    = VALUE_WIDTH'($urandom());
                value[0] = 1'b0;
            end else if (pick < 85) begin
                // square of an odd prime, sits right on the divisor bound
                do
                    root = 64'(2 * $urandom_range(1, 90) + 1);
                while (!is_prime_by_trial_division(VALUE_WIDTH'(root)));
                value = VALUE_WIDTH'(root * root);
            end else begin
                // mid-range values, an occasional larger prime
                value = VALUE_WIDTH'($urandom_range(65536, 1048575));
            end
            pending_candidates.push_back(value);
        end
        total_items = pending_candidates.size();

        // synchronous reset, released at a falling edge
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // every transaction in and every result back, then a short drain
        do
            @(posedge aclk);
        while (items_accepted != total_items || results_seen != total_items);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tdpt_pkg.sv
rtl/trial_division_prime_test_top.sv
verif/tb.sv
